>>> rtl/alarm_manager_with_event_log_assert.svh
// assertion macros of the alarm manager rtl
// expects clk and rst_n in the scope of each use
`ifndef ALARM_MANAGER_WITH_EVENT_LOG_ASSERT_SVH
`define ALARM_MANAGER_WITH_EVENT_LOG_ASSERT_SVH

// invariant checked at every clock edge
`define AMEL_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define AMEL_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/amel_pkg.sv
// types and constants of the alarm manager with event log
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package amel_pkg;

  // command codes on in_cmd
  localparam logic [2:0] CMD_DEFINE    = 3'd0;
  localparam logic [2:0] CMD_RAISE     = 3'd1;
  localparam logic [2:0] CMD_CLEAR     = 3'd2;
  localparam logic [2:0] CMD_CLEAR_ALL = 3'd3;
  localparam logic [2:0] CMD_READ_ACT  = 3'd4;
  localparam logic [2:0] CMD_READ_LOG  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_RECORD  = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // record kinds
  localparam logic [1:0] KIND_EVENT  = 2'd0;
  localparam logic [1:0] KIND_ACTIVE = 2'd1;
  localparam logic [1:0] KIND_LOG    = 2'd2;

  // results emitted by one clear all at most
  localparam int MAX_EMIT = 64;

  typedef enum logic [2:0] {
    OP_DEFINE, OP_RAISE, OP_CLEAR, OP_CLEAR_ALL, OP_READ_ACT, OP_READ_LOG, OP_BAD
  } op_t;

  // classified request passed from front to back
  typedef struct packed {
    op_t         op;
    logic        id_ok;
    logic [6:0]  alarm_id;
    logic        enable;
    logic [7:0]  level;
    logic [7:0]  module_req;
    logic [7:0]  index;
    logic [31:0] timestamp;
  } req_t;

  typedef struct packed {
    logic       en;
    logic [7:0] lvl;
    logic [7:0] modn;
    logic       act;
  } attr_t;

  typedef struct packed {
    logic [6:0]  alarm_id;
    logic [31:0] t;
  } act_ent_t;

  typedef struct packed {
    logic [6:0]  alarm_id;
    logic        on;
    logic [7:0]  lvl;
    logic [7:0]  modn;
    logic [31:0] t;
  } log_ent_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ATTR, S_SCAN, S_SHIFT, S_CA_RD, S_CA_ATTR,
    S_RD_ACT, S_RD_ACT2, S_RD_LOG
  } back_state_t;

endpackage

`default_nettype wire

>>> rtl/alarm_manager_with_event_log.sv
// alarm manager: define/raise/clear alarms, clear all, active list read, event log read.
// bad ids, bad commands and range fails are answered from the idle state; define, raise and
// log read from one execute state, active list read after entry and attribute reads, clear
// after scan and shift; clear all alternates S_CA_RD and S_CA_ATTR, reporting from S_CA_ATTR.
// one request executes at a time while a 2-entry queue takes more; results cannot be stalled.
// after reset busy stays high while the attribute table is cleared.
`timescale 1ns / 1ps
`default_nettype none

module alarm_manager_with_event_log import amel_pkg::*; #(
  parameter int ALARM_COUNT = 64,
  parameter int LOG_DEPTH   = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [6:0]  in_alarm_id,
  input  wire logic        in_enable,
  input  wire logic [7:0]  in_level,
  input  wire logic [7:0]  in_module_req,
  input  wire logic [7:0]  in_index,
  input  wire logic [31:0] in_timestamp,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [1:0]       out_record_kind,
  output logic [6:0]       out_rec_alarm_id,
  output logic             out_rec_on,
  output logic [7:0]       out_rec_level,
  output logic [7:0]       out_rec_module,
  output logic [31:0]      out_rec_time,
  output logic [6:0]       out_active_count,
  output logic [8:0]       out_log_count,
  output logic             out_last
);

  logic q_valid, q_pop, init_busy;
  req_t q_head;

  // request intake and queue
  amel_front #(.ALARM_COUNT(ALARM_COUNT)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_alarm_id(in_alarm_id), .in_enable(in_enable),
    .in_level(in_level), .in_module_req(in_module_req), .in_index(in_index),
    .in_timestamp(in_timestamp), .init_busy(init_busy), .q_pop(q_pop),
    .q_valid(q_valid), .q_head(q_head)
  );

  // executor
  amel_back #(.ALARM_COUNT(ALARM_COUNT), .LOG_DEPTH(LOG_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .init_busy(init_busy), .out_valid(out_valid), .out_status(out_status),
    .out_record_kind(out_record_kind), .out_rec_alarm_id(out_rec_alarm_id),
    .out_rec_on(out_rec_on), .out_rec_level(out_rec_level),
    .out_rec_module(out_rec_module), .out_rec_time(out_rec_time),
    .out_active_count(out_active_count), .out_log_count(out_log_count),
    .out_last(out_last)
  );

endmodule

`default_nettype wire

>>> rtl/amel_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module amel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/amel_front.sv
// front end: takes commands, classifies them, queues them for the back end
// depends on amel_pkg
`timescale 1ns / 1ps
`default_nettype none

module amel_front import amel_pkg::*; #(
  parameter int ALARM_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [6:0]  in_alarm_id,
  input  wire logic        in_enable,
  input  wire logic [7:0]  in_level,
  input  wire logic [7:0]  in_module_req,
  input  wire logic [7:0]  in_index,
  input  wire logic [31:0] in_timestamp,
  input  wire logic        init_busy,
  input  wire logic        q_pop,
  output logic             q_valid,
  output req_t             q_head
);

  req_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       accept;
  req_t       req;

  // classify the command
  always_comb begin
    req.alarm_id   = in_alarm_id;
    req.enable     = in_enable;
    req.level      = in_level;
    req.module_req = in_module_req;
    req.index      = in_index;
    req.timestamp  = in_timestamp;
    req.id_ok      = (in_alarm_id != 7'd0) && (32'(in_alarm_id) <= ALARM_COUNT);
    case (in_cmd)
      CMD_DEFINE:    req.op = OP_DEFINE;
      CMD_RAISE:     req.op = OP_RAISE;
      CMD_CLEAR:     req.op = OP_CLEAR;
      CMD_CLEAR_ALL: req.op = OP_CLEAR_ALL;
      CMD_READ_ACT:  req.op = OP_READ_ACT;
      CMD_READ_LOG:  req.op = OP_READ_LOG;
      default:       req.op = OP_BAD;
    endcase
  end

  assign busy    = cnt_r[1] | init_busy;
  assign accept  = start & ~busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = mem_r[rd_ptr_r];

  // two entry request queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, accept} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[wr_ptr_r] <= req;
    end
  end

endmodule

`default_nettype wire

>>> rtl/amel_back.sv
// back end: executes queued requests on the attribute table, active list and log
// depends on amel_pkg, amel_ram and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "alarm_manager_with_event_log_assert.svh"

module amel_back import amel_pkg::*; #(
  parameter int ALARM_COUNT = 64,
  parameter int LOG_DEPTH   = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire req_t        q_head,
  output logic             q_pop,
  output logic             init_busy,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [1:0]       out_record_kind,
  output logic [6:0]       out_rec_alarm_id,
  output logic             out_rec_on,
  output logic [7:0]       out_rec_level,
  output logic [7:0]       out_rec_module,
  output logic [31:0]      out_rec_time,
  output logic [6:0]       out_active_count,
  output logic [8:0]       out_log_count,
  output logic             out_last
);

  localparam int AW  = $clog2(ALARM_COUNT);
  localparam int LW  = $clog2(LOG_DEPTH);
  localparam int RSW = (LW > 8 ? LW : 8) + 1;

  back_state_t state_r, state_nxt;
  req_t        cur_r, cur_nxt;
  logic [AW:0] scan_r, scan_nxt;
  logic [6:0]  emit_cnt_r, emit_cnt_nxt;
  logic [LW:0] ca_log_r, ca_log_nxt;
  logic [6:0]  ca_id_r, ca_id_nxt;
  act_ent_t    ent_r, ent_nxt;
  logic [7:0]  clr_lvl_r, clr_lvl_nxt, clr_mod_r, clr_mod_nxt;
  logic [AW:0] active_total_r, active_total_nxt;
  logic [LW:0] log_total_r, log_total_nxt;
  logic [LW-1:0] log_oldest_r, log_oldest_nxt;

  // ram ports
  logic          attr_we, act_we, log_we;
  logic [AW-1:0] attr_waddr, attr_raddr, act_waddr, act_raddr;
  logic [LW-1:0] log_waddr, log_raddr;
  attr_t         attr_wdata, attr_rd;
  act_ent_t      act_wdata, act_rd;
  log_ent_t      log_wdata, log_rd;
  logic [17:0]   attr_rdata;
  logic [38:0]   act_rdata;
  logic [55:0]   log_rdata;

  // log append
  logic        do_append;
  log_ent_t    app_ent;
  logic [LW:0] app_sum;
  logic [LW-1:0] app_slot;
  logic        log_full;
  logic [RSW-1:0] rd_sum;
  logic [31:0] ca_sum;

  // result to emit
  logic        emit;
  logic [1:0]  em_status, em_kind;
  logic [6:0]  em_id;
  logic        em_on;
  logic [7:0]  em_lvl, em_mod;
  logic [31:0] em_time;
  logic [6:0]  em_act;
  logic [8:0]  em_log;
  logic        em_last;
  logic        ca_mode;

  logic        out_valid_r;
  logic [1:0]  out_status_r, out_kind_r;
  logic [6:0]  out_id_r;
  logic        out_on_r;
  logic [7:0]  out_lvl_r, out_mod_r;
  logic [31:0] out_time_r;
  logic [6:0]  out_act_r;
  logic [8:0]  out_log_r;
  logic        out_last_r;

  amel_ram #(.WIDTH(18), .DEPTH(ALARM_COUNT)) u_attr (
    .clk(clk), .we(attr_we), .waddr(attr_waddr), .wdata(attr_wdata),
    .raddr(attr_raddr), .rdata(attr_rdata)
  );

  amel_ram #(.WIDTH(39), .DEPTH(ALARM_COUNT)) u_act (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .raddr(act_raddr), .rdata(act_rdata)
  );

  amel_ram #(.WIDTH(56), .DEPTH(LOG_DEPTH)) u_log (
    .clk(clk), .we(log_we), .waddr(log_waddr), .wdata(log_wdata),
    .raddr(log_raddr), .rdata(log_rdata)
  );

  assign attr_rd   = attr_t'(attr_rdata);
  assign act_rd    = act_ent_t'(act_rdata);
  assign log_rd    = log_ent_t'(log_rdata);
  assign init_busy = (state_r == S_INIT);

  // append slot and log address of a read request
  assign log_full = (log_total_r == (LW+1)'(LOG_DEPTH));
  assign app_sum  = (LW+1)'(log_oldest_r) + log_total_r;
  assign app_slot = log_full ? log_oldest_r :
                    (app_sum >= (LW+1)'(LOG_DEPTH)) ? LW'(app_sum - (LW+1)'(LOG_DEPTH))
                                                    : LW'(app_sum);
  assign rd_sum   = RSW'(log_oldest_r) + RSW'(q_head.index);
  assign ca_sum   = 32'(log_total_r) + 32'(active_total_r);

  // sequencer: next state and ram controls
  always_comb begin
    state_nxt        = state_r;
    cur_nxt          = cur_r;
    scan_nxt         = scan_r;
    emit_cnt_nxt     = emit_cnt_r;
    ca_log_nxt       = ca_log_r;
    ca_id_nxt        = ca_id_r;
    ent_nxt          = ent_r;
    clr_lvl_nxt      = clr_lvl_r;
    clr_mod_nxt      = clr_mod_r;
    active_total_nxt = active_total_r;
    q_pop      = 1'b0;
    attr_we    = 1'b0;
    attr_waddr = AW'(32'(cur_r.alarm_id) - 32'd1);
    attr_wdata = attr_rd;
    attr_raddr = AW'(32'(cur_r.alarm_id) - 32'd1);
    act_we     = 1'b0;
    act_waddr  = AW'(active_total_r);
    act_wdata  = act_rd;
    act_raddr  = AW'(scan_r);
    log_raddr  = (rd_sum >= RSW'(LOG_DEPTH)) ? LW'(rd_sum - RSW'(LOG_DEPTH)) : LW'(rd_sum);
    do_append  = 1'b0;
    app_ent    = '0;
    emit       = 1'b0;
    em_status  = ST_DONE;
    em_kind    = KIND_EVENT;
    em_id      = 7'd0;
    em_on      = 1'b0;
    em_lvl     = 8'd0;
    em_mod     = 8'd0;
    em_time    = 32'd0;
    em_last    = 1'b1;
    ca_mode    = 1'b0;
    case (state_r)
      S_INIT: begin
        // clearing pass over the attribute table
        attr_we    = 1'b1;
        attr_waddr = AW'(scan_r);
        attr_wdata = '0;
        scan_nxt   = scan_r + 1'b1;
        if (32'(scan_r) == ALARM_COUNT - 1) begin
          scan_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cur_nxt    = q_head;
          attr_raddr = AW'(32'(q_head.alarm_id) - 32'd1);
          act_raddr  = AW'(q_head.index);
          case (q_head.op)
            OP_DEFINE, OP_RAISE, OP_CLEAR: begin
              if (q_head.id_ok) begin
                state_nxt = S_ATTR;
              end else begin
                emit      = 1'b1;
                em_status = ST_IGNORED;
              end
            end
            OP_CLEAR_ALL: begin
              if (active_total_r == '0) begin
                emit = 1'b1;
              end else begin
                scan_nxt     = '0;
                emit_cnt_nxt = 7'd0;
                act_raddr    = '0;
                ca_log_nxt   = (ca_sum > LOG_DEPTH) ? (LW+1)'(LOG_DEPTH) : (LW+1)'(ca_sum);
                state_nxt    = S_CA_RD;
              end
            end
            OP_READ_ACT: begin
              if (32'(q_head.index) < 32'(active_total_r)) begin
                state_nxt = S_RD_ACT;
              end else begin
                emit      = 1'b1;
                em_status = ST_RANGE;
              end
            end
            OP_READ_LOG: begin
              if (32'(q_head.index) < 32'(log_total_r)) begin
                state_nxt = S_RD_LOG;
              end else begin
                emit      = 1'b1;
                em_status = ST_RANGE;
              end
            end
            default: begin
              emit      = 1'b1;
              em_status = ST_IGNORED;
            end
          endcase
        end
      end
      S_ATTR: begin
        state_nxt = S_IDLE;
        case (cur_r.op)
          OP_DEFINE: begin
            attr_we         = 1'b1;
            attr_wdata.en   = cur_r.enable;
            attr_wdata.lvl  = cur_r.level;
            attr_wdata.modn = cur_r.module_req;
            emit            = 1'b1;
          end
          OP_RAISE: begin
            if (!attr_rd.en || attr_rd.act || 32'(active_total_r) >= ALARM_COUNT) begin
              emit      = 1'b1;
              em_status = ST_IGNORED;
            end else begin
              attr_we            = 1'b1;
              attr_wdata.act     = 1'b1;
              act_we             = 1'b1;
              act_wdata.alarm_id = cur_r.alarm_id;
              act_wdata.t        = cur_r.timestamp;
              active_total_nxt   = active_total_r + 1'b1;
              do_append          = 1'b1;
              app_ent            = '{cur_r.alarm_id, 1'b1, attr_rd.lvl, attr_rd.modn,
                                     cur_r.timestamp};
            end
          end
          OP_CLEAR: begin
            if (!attr_rd.en || !attr_rd.act) begin
              emit      = 1'b1;
              em_status = ST_IGNORED;
            end else begin
              attr_we        = 1'b1;
              attr_wdata.act = 1'b0;
              clr_lvl_nxt    = attr_rd.lvl;
              clr_mod_nxt    = attr_rd.modn;
              scan_nxt       = '0;
              act_raddr      = '0;
              state_nxt      = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        // search the active list for the cleared alarm
        if (scan_r >= active_total_r) begin
          do_append = 1'b1;
          app_ent   = '{cur_r.alarm_id, 1'b0, clr_lvl_r, clr_mod_r, cur_r.timestamp};
          state_nxt = S_IDLE;
        end else if (act_rd.alarm_id == cur_r.alarm_id) begin
          act_raddr = AW'(scan_r + 1'b1);
          state_nxt = S_SHIFT;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          act_raddr = AW'(scan_r + 1'b1);
        end
      end
      S_SHIFT: begin
        // close the gap one entry a cycle
        if (scan_r + 1'b1 < active_total_r) begin
          act_we    = 1'b1;
          act_waddr = AW'(scan_r);
          act_wdata = act_rd;
          scan_nxt  = scan_r + 1'b1;
          act_raddr = AW'(scan_r + 2'd2);
        end else begin
          active_total_nxt = active_total_r - 1'b1;
          do_append        = 1'b1;
          app_ent          = '{cur_r.alarm_id, 1'b0, clr_lvl_r, clr_mod_r, cur_r.timestamp};
          state_nxt        = S_IDLE;
        end
      end
      S_CA_RD: begin
        ca_id_nxt  = act_rd.alarm_id;
        attr_raddr = AW'(32'(act_rd.alarm_id) - 32'd1);
        state_nxt  = S_CA_ATTR;
      end
      S_CA_ATTR: begin
        // turn one alarm off, log it and, below MAX_EMIT results, report it
        attr_we        = 1'b1;
        attr_waddr     = AW'(32'(ca_id_r) - 32'd1);
        attr_wdata.act = 1'b0;
        do_append      = 1'b1;
        app_ent        = '{ca_id_r, 1'b0, attr_rd.lvl, attr_rd.modn, cur_r.timestamp};
        ca_mode        = 1'b1;
        if (32'(emit_cnt_r) >= MAX_EMIT) begin
          emit = 1'b0;
        end
        em_last = (scan_r + 1'b1 == active_total_r) || (32'(emit_cnt_r) == MAX_EMIT - 1);
        if (32'(emit_cnt_r) < MAX_EMIT) begin
          emit_cnt_nxt = emit_cnt_r + 1'b1;
        end
        if (scan_r + 1'b1 < active_total_r) begin
          scan_nxt  = scan_r + 1'b1;
          act_raddr = AW'(scan_r + 1'b1);
          state_nxt = S_CA_RD;
        end else begin
          active_total_nxt = '0;
          state_nxt        = S_IDLE;
        end
      end
      S_RD_ACT: begin
        ent_nxt    = act_rd;
        attr_raddr = AW'(32'(act_rd.alarm_id) - 32'd1);
        state_nxt  = S_RD_ACT2;
      end
      S_RD_ACT2: begin
        emit      = 1'b1;
        em_status = ST_RECORD;
        em_kind   = KIND_ACTIVE;
        em_id     = ent_r.alarm_id;
        em_on     = 1'b1;
        em_lvl    = attr_rd.lvl;
        em_mod    = attr_rd.modn;
        em_time   = ent_r.t;
        state_nxt = S_IDLE;
      end
      S_RD_LOG: begin
        emit      = 1'b1;
        em_status = ST_RECORD;
        em_kind   = KIND_LOG;
        em_id     = log_rd.alarm_id;
        em_on     = log_rd.on;
        em_lvl    = log_rd.lvl;
        em_mod    = log_rd.modn;
        em_time   = log_rd.t;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // append an event to the log and report it (in clear all only below MAX_EMIT results)
    log_we         = do_append;
    log_waddr      = app_slot;
    log_wdata      = app_ent;
    log_total_nxt  = log_total_r;
    log_oldest_nxt = log_oldest_r;
    if (do_append) begin
      if (log_full) begin
        log_oldest_nxt = (32'(log_oldest_r) == LOG_DEPTH - 1) ? '0 : log_oldest_r + 1'b1;
      end else begin
        log_total_nxt = log_total_r + 1'b1;
      end
      emit      = ca_mode ? (32'(emit_cnt_r) < MAX_EMIT) : 1'b1;
      em_status = ST_RECORD;
      em_kind   = KIND_EVENT;
      em_id     = app_ent.alarm_id;
      em_on     = app_ent.on;
      em_lvl    = app_ent.lvl;
      em_mod    = app_ent.modn;
      em_time   = app_ent.t;
    end
    em_act = ca_mode ? 7'd0 : 7'(active_total_nxt);
    em_log = ca_mode ? 9'(ca_log_r) : 9'(log_total_nxt);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_INIT;
      scan_r         <= '0;
      emit_cnt_r     <= 7'd0;
      active_total_r <= '0;
      log_total_r    <= '0;
      log_oldest_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      scan_r         <= scan_nxt;
      emit_cnt_r     <= emit_cnt_nxt;
      active_total_r <= active_total_nxt;
      log_total_r    <= log_total_nxt;
      log_oldest_r   <= log_oldest_nxt;
      out_valid_r    <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    ca_log_r  <= ca_log_nxt;
    ca_id_r   <= ca_id_nxt;
    ent_r     <= ent_nxt;
    clr_lvl_r <= clr_lvl_nxt;
    clr_mod_r <= clr_mod_nxt;
    if (emit) begin
      out_status_r <= em_status;
      out_kind_r   <= em_kind;
      out_id_r     <= em_id;
      out_on_r     <= em_on;
      out_lvl_r    <= em_lvl;
      out_mod_r    <= em_mod;
      out_time_r   <= em_time;
      out_act_r    <= em_act;
      out_log_r    <= em_log;
      out_last_r   <= em_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_record_kind  = out_kind_r;
  assign out_rec_alarm_id = out_id_r;
  assign out_rec_on       = out_on_r;
  assign out_rec_level    = out_lvl_r;
  assign out_rec_module   = out_mod_r;
  assign out_rec_time     = out_time_r;
  assign out_active_count = out_act_r;
  assign out_log_count    = out_log_r;
  assign out_last         = out_last_r;

  // checks
  `AMEL_CHECK(a_act_bound, 32'(active_total_r) <= ALARM_COUNT, "active count overflow")
  `AMEL_CHECK(a_log_bound, (32'(log_total_r) <= LOG_DEPTH) && (32'(log_oldest_r) < LOG_DEPTH), "log pointers out of range")
  `AMEL_IMPLY(a_pop_idle, q_pop, (state_r == S_IDLE) && q_valid, "request taken while not idle")
  `AMEL_IMPLY(a_oldest_full, log_oldest_nxt != log_oldest_r, log_full && do_append, "oldest entry dropped while log not full")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench of the alarm manager with event log
// depends on amel_pkg and alarm_manager_with_event_log; predicts every result in-line
`timescale 1ns / 1ps

module tb_top;
  import amel_pkg::*;

  localparam int NUM_ALARMS = 64;
  localparam int LOG_SLOTS  = 256;
  localparam int EMIT_LIMIT = 64;
  localparam int CYCLE_LIMIT = 500000;
  // command codes with no meaning
  localparam logic [2:0] CMD_UNDEF_A = 3'd6;
  localparam logic [2:0] CMD_UNDEF_B = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [6:0]  alarm_id;
    logic        on;
    logic [7:0]  level;
    logic [7:0]  modn;
    logic [31:0] t;
    logic [6:0]  active_count;
    logic [8:0]  log_count;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0]  in_cmd;
  logic [6:0]  in_alarm_id;
  logic        in_enable;
  logic [7:0]  in_level;
  logic [7:0]  in_module_req;
  logic [7:0]  in_index;
  logic [31:0] in_timestamp;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [1:0]  out_record_kind;
  logic [6:0]  out_rec_alarm_id;
  logic        out_rec_on;
  logic [7:0]  out_rec_level;
  logic [7:0]  out_rec_module;
  logic [31:0] out_rec_time;
  logic [6:0]  out_active_count;
  logic [8:0]  out_log_count;
  logic        out_last;

  // predictor state
  logic        alarm_en  [1:NUM_ALARMS];
  logic [7:0]  alarm_lvl [1:NUM_ALARMS];
  logic [7:0]  alarm_mod [1:NUM_ALARMS];
  logic        alarm_act [1:NUM_ALARMS];
  logic [6:0]  list_id   [NUM_ALARMS];
  logic [31:0] list_time [NUM_ALARMS];
  int          list_total;
  log_ent_t    log_store [LOG_SLOTS];
  int          log_head;
  int          log_total;

  result_t expected_results[$];
  result_t item_results[$];
  int      mismatches;
  int      idle_pct;
  int      cycles;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  alarm_manager_with_event_log i_dut (
    .clk, .rst_n, .start, .busy,
    .in_cmd, .in_alarm_id, .in_enable, .in_level, .in_module_req, .in_index, .in_timestamp,
    .out_valid, .out_status, .out_record_kind, .out_rec_alarm_id, .out_rec_on,
    .out_rec_level, .out_rec_module, .out_rec_time, .out_active_count, .out_log_count,
    .out_last
  );

  function automatic result_t plain_result(logic [1:0] st);
    result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  // append one event to the log, drop the oldest when full
  function automatic void log_append(logic [6:0] id, logic on, logic [31:0] ts);
    int slot;
    result_t r;
    if (log_total < LOG_SLOTS) begin
      slot = (log_head + log_total) % LOG_SLOTS;
      log_total++;
    end else begin
      slot = log_head;
      log_head = (log_head + 1) % LOG_SLOTS;
    end
    log_store[slot] = '{id, on, alarm_lvl[id], alarm_mod[id], ts};
    if (item_results.size() < EMIT_LIMIT) begin
      r = '0;
      r.status = ST_RECORD;
      r.kind = KIND_EVENT;
      r.alarm_id = id;
      r.on = on;
      r.level = alarm_lvl[id];
      r.modn = alarm_mod[id];
      r.t = ts;
      item_results.push_back(r);
    end
  endfunction

  // work out the results of one accepted request
  function automatic void predict_alarm_request(logic [2:0] c, logic [6:0] id, logic en,
      logic [7:0] lvl, logic [7:0] mdl, logic [7:0] idx, logic [31:0] ts);
    logic valid;
    int pos;
    result_t r;
    valid = id >= 1 && id <= NUM_ALARMS;
    item_results.delete();
    case (c)
      CMD_DEFINE: begin
        if (valid) begin
          alarm_en[id] = en;
          alarm_lvl[id] = lvl;
          alarm_mod[id] = mdl;
          item_results.push_back(plain_result(ST_DONE));
        end else begin
          item_results.push_back(plain_result(ST_IGNORED));
        end
      end
      CMD_RAISE: begin
        if (!valid || !alarm_en[id] || alarm_act[id] || list_total >= NUM_ALARMS) begin
          item_results.push_back(plain_result(ST_IGNORED));
        end else begin
          alarm_act[id] = 1'b1;
          list_id[list_total] = id;
          list_time[list_total] = ts;
          list_total++;
          log_append(id, 1'b1, ts);
        end
      end
      CMD_CLEAR: begin
        if (!valid || !alarm_en[id] || !alarm_act[id]) begin
          item_results.push_back(plain_result(ST_IGNORED));
        end else begin
          alarm_act[id] = 1'b0;
          pos = 0;
          while (pos < list_total && list_id[pos] != id) pos++;
          // close the gap left by the cleared alarm
          if (pos < list_total) begin
            for (int j = pos; j + 1 < list_total; j++) begin
              list_id[j] = list_id[j + 1];
              list_time[j] = list_time[j + 1];
            end
            list_total--;
          end
          log_append(id, 1'b0, ts);
        end
      end
      CMD_CLEAR_ALL: begin
        for (int j = 0; j < list_total; j++) begin
          alarm_act[list_id[j]] = 1'b0;
          log_append(list_id[j], 1'b0, ts);
        end
        list_total = 0;
        if (item_results.size() == 0) item_results.push_back(plain_result(ST_DONE));
      end
      CMD_READ_ACT: begin
        if (idx < list_total) begin
          r = '0;
          r.status = ST_RECORD;
          r.kind = KIND_ACTIVE;
          r.alarm_id = list_id[idx];
          r.on = 1'b1;
          r.level = alarm_lvl[list_id[idx]];
          r.modn = alarm_mod[list_id[idx]];
          r.t = list_time[idx];
          item_results.push_back(r);
        end else begin
          item_results.push_back(plain_result(ST_RANGE));
        end
      end
      CMD_READ_LOG: begin
        if (idx < log_total) begin
          r = '0;
          r.status = ST_RECORD;
          r.kind = KIND_LOG;
          r.alarm_id = log_store[(log_head + idx) % LOG_SLOTS].alarm_id;
          r.on = log_store[(log_head + idx) % LOG_SLOTS].on;
          r.level = log_store[(log_head + idx) % LOG_SLOTS].lvl;
          r.modn = log_store[(log_head + idx) % LOG_SLOTS].modn;
          r.t = log_store[(log_head + idx) % LOG_SLOTS].t;
          item_results.push_back(r);
        end else begin
          item_results.push_back(plain_result(ST_RANGE));
        end
      end
      default: item_results.push_back(plain_result(ST_IGNORED));
    endcase
    foreach (item_results[k]) begin
      r = item_results[k];
      r.active_count = list_total[6:0];
      r.log_count = log_total[8:0];
      r.last = (k == item_results.size() - 1);
      expected_results.push_back(r);
    end
  endfunction

  // maybe idle first, send one request, predict it on acceptance
  task automatic send_request(logic [2:0] c, logic [6:0] id, logic en, logic [7:0] lvl,
      logic [7:0] mdl, logic [7:0] idx, logic [31:0] ts);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= c;
    in_alarm_id <= id;
    in_enable <= en;
    in_level <= lvl;
    in_module_req <= mdl;
    in_index <= idx;
    in_timestamp <= ts;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_alarm_request(c, id, en, lvl, mdl, idx, ts);
  endtask

  // stop sending until every expected result has come
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed();
    // invalid ids and undefined commands
    send_request(CMD_DEFINE, 7'd0, 1'b1, 8'hFF, 8'hFF, 8'd0, 32'd0);
    send_request(CMD_DEFINE, 7'd65, 1'b1, 8'd1, 8'd1, 8'd0, 32'd0);
    send_request(CMD_RAISE, 7'd127, 1'b0, 8'd0, 8'd0, 8'hFF, 32'hFFFF_FFFF);
    send_request(CMD_UNDEF_A, 7'd1, 1'b1, 8'd0, 8'd0, 8'd0, 32'd0);
    send_request(CMD_UNDEF_B, 7'd1, 1'b1, 8'd0, 8'd0, 8'd0, 32'd0);
    // empty reads and empty clear all
    send_request(CMD_READ_ACT, 7'd0, 1'b0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_request(CMD_READ_LOG, 7'd0, 1'b0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_request(CMD_CLEAR_ALL, 7'd0, 1'b0, 8'd0, 8'd0, 8'd0, 32'd5);
    // raise of a disabled alarm is ignored
    send_request(CMD_RAISE, 7'd1, 1'b0, 8'd0, 8'd0, 8'd0, 32'd10);
    send_request(CMD_DEFINE, 7'd1, 1'b1, 8'hFF, 8'h00, 8'd0, 32'd0);
    send_request(CMD_DEFINE, 7'd64, 1'b1, 8'h00, 8'hFF, 8'd0, 32'd0);
    send_request(CMD_DEFINE, 7'd2, 1'b1, 8'h5A, 8'hA5, 8'd0, 32'd0);
    send_request(CMD_RAISE, 7'd1, 1'b0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_request(CMD_RAISE, 7'd1, 1'b0, 8'd0, 8'd0, 8'd0, 32'd11);
    send_request(CMD_RAISE, 7'd64, 1'b0, 8'd0, 8'd0, 8'd0, 32'h8000_0000);
    send_request(CMD_RAISE, 7'd2, 1'b0, 8'd0, 8'd0, 8'd0, 32'h0000_0001);
    // redefine keeps the active flag; then a disabled active alarm cannot be cleared
    send_request(CMD_DEFINE, 7'd2, 1'b0, 8'h11, 8'h22, 8'd0, 32'd0);
    send_request(CMD_CLEAR, 7'd2, 1'b0, 8'd0, 8'd0, 8'd0, 32'd12);
    // clear from the head closes the gap
    send_request(CMD_CLEAR, 7'd1, 1'b0, 8'd0, 8'd0, 8'd0, 32'd13);
    send_request(CMD_CLEAR, 7'd1, 1'b0, 8'd0, 8'd0, 8'd0, 32'd14);
    send_request(CMD_READ_ACT, 7'd0, 1'b0, 8'd0, 8'd0, 8'd1, 32'd0);
    send_request(CMD_READ_ACT, 7'd0, 1'b0, 8'd0, 8'd0, 8'd255, 32'd0);
    send_request(CMD_READ_LOG, 7'd0, 1'b0, 8'd0, 8'd0, 8'd3, 32'd0);
    // clear all takes the disabled active alarm too
    send_request(CMD_CLEAR_ALL, 7'd0, 1'b0, 8'd0, 8'd0, 8'd0, 32'd20);
    send_request(CMD_READ_LOG, 7'd0, 1'b0, 8'd0, 8'd0, 8'd255, 32'd0);
    drain_results();
  endtask

  // every alarm raised then cleared at once: maximum burst
  task automatic test_full_burst();
    for (int id = 1; id <= NUM_ALARMS; id++)
      send_request(CMD_DEFINE, id[6:0], 1'b1, 8'($urandom), 8'($urandom), 8'd0, 32'd0);
    for (int id = NUM_ALARMS; id >= 1; id--)
      send_request(CMD_RAISE, id[6:0], 1'b0, 8'd0, 8'd0, 8'd0, $urandom);
    send_request(CMD_READ_ACT, 7'd0, 1'b0, 8'd0, 8'd0, 8'd63, 32'd0);
    send_request(CMD_READ_ACT, 7'd0, 1'b0, 8'd0, 8'd0, 8'd64, 32'd0);
    send_request(CMD_CLEAR_ALL, 7'd0, 1'b0, 8'd0, 8'd0, 8'd0, $urandom);
    drain_results();
  endtask

  task automatic test_random(int count);
    int pick;
    logic [6:0] id;
    logic [7:0] idx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      // most ids come from a small pool so raise and clear meet often
      if ($urandom_range(9) == 0) id = 7'($urandom_range(127));
      else if ($urandom_range(4) == 0) id = 7'($urandom_range(1, NUM_ALARMS));
      else id = 7'($urandom_range(1, 10));
      if (pick < 12) begin
        send_request(CMD_DEFINE, id, $urandom_range(3) != 0, 8'($urandom), 8'($urandom),
                     8'($urandom), $urandom);
      end else if (pick < 45) begin
        send_request(CMD_RAISE, id, 1'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), $urandom);
      end else if (pick < 70) begin
        send_request(CMD_CLEAR, id, 1'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), $urandom);
      end else if (pick < 74) begin
        send_request(CMD_CLEAR_ALL, id, 1'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), $urandom);
      end else if (pick < 85) begin
        idx = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(list_total));
        send_request(CMD_READ_ACT, id, 1'($urandom), 8'($urandom), 8'($urandom), idx, $urandom);
      end else if (pick < 97) begin
        idx = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(log_total));
        send_request(CMD_READ_LOG, id, 1'($urandom), 8'($urandom), 8'($urandom), idx, $urandom);
      end else begin
        send_request($urandom_range(1) ? CMD_UNDEF_A : CMD_UNDEF_B, id, 1'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), $urandom);
      end
    end
  endtask

  // compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid) begin
      got = '{out_status, out_record_kind, out_rec_alarm_id, out_rec_on, out_rec_level,
              out_rec_module, out_rec_time, out_active_count, out_log_count, out_last};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    idle_pct = 8;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_DEFINE;
    in_alarm_id = '0;
    in_enable = 1'b0;
    in_level = '0;
    in_module_req = '0;
    in_index = '0;
    in_timestamp = '0;
    list_total = 0;
    log_head = 0;
    log_total = 0;
    for (int id = 1; id <= NUM_ALARMS; id++) begin
      alarm_en[id] = 1'b0;
      alarm_lvl[id] = '0;
      alarm_mod[id] = '0;
      alarm_act[id] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_burst();
    idle_pct = 8;
    test_random(5);
    drain_results();
    idle_pct = 48;
    test_random(5);
    drain_results();
    idle_pct = 0;
    test_random(5);
    drain_results();
    repeat (200) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
